FILE: rtl/core/bfsp_pkg.sv
// bfsp_pkg: shared types, constants and probe formation for the six-probe bloom filter
// no dependencies; imported by bfsp_store, bfsp_ctrl and bloom_filter_six_probe_unit
`default_nettype none

package bfsp_pkg;

  // filter geometry
  localparam int INDEX_BITS  = 24;
  localparam int ADDR_BITS   = INDEX_BITS - 3;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;
  localparam int PROBE_COUNT = 6;
  localparam int CNT_BITS    = $clog2(PROBE_COUNT);

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef logic [INDEX_BITS-1:0] probe_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  // one cycle of requests to the filter store
  typedef struct packed {
    logic       re;
    addr_t      raddr;
    logic       we;
    addr_t      waddr;
    logic [7:0] wdata;
  } mem_req_t;

  // probe n of a digest; digest byte 0 sits in key[127:120]
  function automatic probe_t make_probe(input logic [127:0] key, input logic [15:0] crc,
                                        input int n);
    int         base;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    probe_t     p;
    base = 1 + 3 * (n - 1);
    if (n == 0) begin
      p = {key[127:120], crc};
    end else begin
      // three bytes read little-endian
      b0 = key[127 - 8 * base -: 8];
      b1 = key[127 - 8 * (base + 1) -: 8];
      b2 = key[127 - 8 * (base + 2) -: 8];
      p  = {b2, b1, b0};
    end
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bfsp_store.sv
// bfsp_store: byte-wide filter memory, one write and one registered read per cycle
// depends on bfsp_pkg for geometry and the request struct
`default_nettype none

module bfsp_store
  import bfsp_pkg::*;
(
  input  wire logic       clk_i,
  input  mem_req_t        req_i,
  output logic      [7:0] rdata_o
);

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/bfsp_ctrl.sv
// bfsp_ctrl: clearing pass, probe sequencer and read-modify-write datapath
// depends on bfsp_pkg; drives the request struct of bfsp_store
`default_nettype none

module bfsp_ctrl
  import bfsp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire logic         func_i,
  input  wire logic [63:0]  key_high_i,
  input  wire logic [63:0]  key_low_i,
  input  wire logic [15:0]  key_crc_i,
  output logic              result_valid_o,
  output logic              may_contain_o,
  output mem_req_t          req_o,
  input  wire logic [7:0]   rdata_i
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } state_e;

  localparam logic [CNT_BITS-1:0] CNT_FIRST = CNT_BITS'(1);
  localparam logic [CNT_BITS-1:0] CNT_LAST  = CNT_BITS'(PROBE_COUNT - 1);
  localparam addr_t               ADDR_MAX  = {ADDR_BITS{1'b1}};

  state_e              state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  addr_t               clr_addr_q, clr_addr_d;
  probe_t              probe_q [PROBE_COUNT];
  probe_t              probe_in [PROBE_COUNT];
  logic                func_q, func_d;

  // data stage of the read-modify-write
  logic                dat_valid_q, dat_valid_d;
  addr_t               dat_addr_q, dat_addr_d;
  logic [2:0]          dat_sel_q, dat_sel_d;
  logic                dat_first_q, dat_first_d;
  logic                dat_last_q, dat_last_d;
  logic                dat_func_q, dat_func_d;
  logic                acc_q, acc_d;

  // copy of the write issued alongside the last read
  logic                fwd_valid_q;
  addr_t               fwd_addr_q;
  logic [7:0]          fwd_data_q;

  logic                res_valid_q, res_valid_d;
  logic                res_hit_q, res_hit_d;

  logic                accept;
  probe_t              iss_probe;
  logic                iss_valid;
  logic [7:0]          cur_byte;
  logic [7:0]          bit_mask;
  logic                bit_hit;
  logic                acc_new;
  mem_req_t            req;

  assign accept = start && (state_q == ST_IDLE);

  // probe formation from the input ports
  always_comb begin
    for (int n = 0; n < PROBE_COUNT; n++) begin
      probe_in[n] = make_probe({key_high_i, key_low_i}, key_crc_i, n);
    end
  end

  // issue: probe 0 straight from the ports, the rest from the probe registers
  always_comb begin
    iss_valid = 1'b0;
    iss_probe = probe_q[cnt_q];
    case (state_q)
      ST_IDLE: begin
        iss_valid = accept;
        iss_probe = probe_in[0];
      end
      ST_RUN: begin
        iss_valid = 1'b1;
      end
      default: begin
        iss_valid = 1'b0;
      end
    endcase
  end

  // merge the write that the memory read could not see yet
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == dat_addr_q)) begin
      cur_byte = fwd_data_q;
    end else begin
      cur_byte = rdata_i;
    end
    bit_mask = 8'h80 >> dat_sel_q;
    bit_hit  = |(cur_byte & bit_mask);
    acc_new  = dat_first_q ? bit_hit : (acc_q & bit_hit);
  end

  // memory requests: probe reads, clearing pass or insert write-back
  always_comb begin
    req       = '0;
    req.re    = iss_valid;
    req.raddr = iss_probe[INDEX_BITS-1:3];
    if (state_q == ST_CLEAR) begin
      req.we    = 1'b1;
      req.waddr = clr_addr_q;
      req.wdata = 8'h00;
    end else if (dat_valid_q && (dat_func_q == FUNC_INSERT)) begin
      req.we    = 1'b1;
      req.waddr = dat_addr_q;
      req.wdata = cur_byte | bit_mask;
    end
  end

  assign req_o = req;

  // next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_addr_d  = clr_addr_q;
    func_d      = func_q;
    dat_valid_d = iss_valid;
    dat_addr_d  = iss_probe[INDEX_BITS-1:3];
    dat_sel_d   = iss_probe[2:0];
    dat_first_d = (state_q == ST_IDLE);
    dat_last_d  = (state_q == ST_RUN) && (cnt_q == CNT_LAST);
    dat_func_d  = (state_q == ST_IDLE) ? func_i : func_q;
    acc_d       = dat_valid_q ? acc_new : acc_q;
    res_valid_d = dat_valid_q && dat_last_q && (dat_func_q == FUNC_QUERY);
    res_hit_d   = acc_new;
    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == ADDR_MAX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          cnt_d   = CNT_FIRST;
          func_d  = func_i;
        end
      end
      ST_RUN: begin
        if (cnt_q == CNT_LAST) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      clr_addr_q  <= '0;
      dat_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_addr_q  <= clr_addr_d;
      dat_valid_q <= dat_valid_d;
      fwd_valid_q <= req.we;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int n = 0; n < PROBE_COUNT; n++) begin
        probe_q[n] <= probe_in[n];
      end
    end
    func_q      <= func_d;
    dat_addr_q  <= dat_addr_d;
    dat_sel_q   <= dat_sel_d;
    dat_first_q <= dat_first_d;
    dat_last_q  <= dat_last_d;
    dat_func_q  <= dat_func_d;
    acc_q       <= acc_d;
    fwd_addr_q  <= req.waddr;
    fwd_data_q  <= req.wdata;
    res_hit_q   <= res_hit_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign may_contain_o  = res_hit_q;

  // an accepted item starts the probe sequence at the second probe
  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN) && (cnt_q == CNT_FIRST))
    else $error("accepted item did not start the probe sequence");

  // a result strobe follows the data stage of the last probe of a query
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(dat_valid_q && dat_last_q && (dat_func_q == FUNC_QUERY)))
    else $error("result strobe without a finished query");

  // outside the clearing pass only an insert writes the store
  a_write_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_CLEAR) && req.we |-> dat_valid_q && (dat_func_q == FUNC_INSERT))
    else $error("store written outside an insert");

  // the last probe's data stage lines up with the return to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dat_valid_q && dat_last_q |-> (state_q == ST_IDLE))
    else $error("last probe data stage not aligned with idle");

endmodule

`default_nettype wire

FILE: rtl/core/bloom_filter_six_probe_unit.sv
// a query result is registered from its last probe's data stage; inserts give no result
// throughput: a new item once busy drops, one probe read per cycle on the store's read port,
//   write-back of the previous probe on the write port with forwarding of same-byte hits
// reset: a clearing pass zeroes the 2^21-byte store with busy high throughout
// the receiver cannot stall: result_valid_o and may_contain_o hold for exactly one cycle
// depends on bfsp_pkg, bfsp_ctrl and bfsp_store
`default_nettype none

module bloom_filter_six_probe_unit
  import bfsp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire logic         func_i,
  input  wire logic [63:0]  key_high_i,
  input  wire logic [63:0]  key_low_i,
  input  wire logic [15:0]  key_crc_i,
  output logic              result_valid_o,
  output logic              may_contain_o
);

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  // sequencer and read-modify-write datapath
  bfsp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .key_high_i     (key_high_i),
    .key_low_i      (key_low_i),
    .key_crc_i      (key_crc_i),
    .result_valid_o (result_valid_o),
    .may_contain_o  (may_contain_o),
    .req_o          (mem_req),
    .rdata_i        (mem_rdata)
  );

  // filter bit array
  bfsp_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: tb/bloom_filter_six_probe_unit_tb.sv
// testbench for bloom_filter_six_probe_unit: directed and random insert/query traffic
// checked against a bit-level filter predictor in a small scoreboard class
// depends on bfsp_pkg and the bloom_filter_six_probe_unit rtl
`timescale 1ns / 1ps

module bloom_filter_six_probe_unit_tb;
  import bfsp_pkg::*;

  localparam int RANDOM_ITEMS = 1030;
  // clearing pass after reset, then every item at its longest gap plus its own cycles
  localparam int CYCLE_LIMIT  = 3 * (STORE_DEPTH + 20 * (RANDOM_ITEMS + 50) + 1000);
  localparam int TAIL_CYCLES  = 16;

  typedef bit [INDEX_BITS-1:0] bit_index_t;

  typedef struct packed {
    logic        func;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [15:0] key_crc;
  } key_item_t;

  // filter contents and pending query answers
  class bloom_scoreboard;
    bit filter_bits [bit_index_t];
    bit answer_q [$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // apply one accepted item to the filter copy
    function void note_transfer(key_item_t it);
      logic [127:0] key;
      logic [7:0]   digest [16];
      bit_index_t   idx;
      bit           all_set;
      key     = {it.key_high, it.key_low};
      all_set = 1'b1;
      for (int k = 0; k < 16; k++) begin
        digest[k] = key[8 * (15 - k) +: 8];
      end
      for (int n = 0; n < PROBE_COUNT; n++) begin
        // probe 0 mixes the crc in; the rest take three digest bytes, low byte first
        if (n == 0) begin
          idx = {digest[0], it.key_crc};
        end else begin
          idx = {digest[3 * n], digest[3 * n - 1], digest[3 * n - 2]};
        end
        if (it.func == FUNC_INSERT) begin
          filter_bits[idx] = 1'b1;
        end else if (!filter_bits.exists(idx)) begin
          all_set = 1'b0;
        end
      end
      if (it.func == FUNC_QUERY) begin
        answer_q = {answer_q, all_set};
      end
    endfunction

    // compare one strobed answer with the oldest pending query
    function void check_result(logic may_contain);
      bit want;
      if (answer_q.size() == 0) begin
        $error("may_contain: no query pending, actual %0b", may_contain);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (may_contain !== want) begin
          $error("may_contain: expected %0b, actual %0b", want, may_contain);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        func_i;
  logic [63:0] key_high_i;
  logic [63:0] key_low_i;
  logic [15:0] key_crc_i;
  logic        result_valid_o;
  logic        may_contain_o;

  bloom_scoreboard sb;
  key_item_t       pool [$];
  bit              no_idle;
  int              cycle_count;

  bloom_filter_six_probe_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .key_high_i     (key_high_i),
    .key_low_i      (key_low_i),
    .key_crc_i      (key_crc_i),
    .result_valid_o (result_valid_o),
    .may_contain_o  (may_contain_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bloom_filter_six_probe_unit_tb NOT OK");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      sb.check_result(may_contain_o);
    end
  end

  // build an item whose six probe indices are given, packed as {p5, p4, p3, p2, p1, p0}
  function automatic key_item_t from_probes(logic func,
                                            logic [PROBE_COUNT*INDEX_BITS-1:0] p);
    logic [127:0] key;
    logic [23:0]  v;
    key_item_t    it;
    key        = '0;
    it.func    = func;
    it.key_crc = p[15:0];
    key[127:120] = p[23:16];
    for (int n = 1; n < PROBE_COUNT; n++) begin
      v = p[n * INDEX_BITS +: INDEX_BITS];
      key[127 - 8 * (3 * n - 2) -: 8] = v[7:0];
      key[127 - 8 * (3 * n - 1) -: 8] = v[15:8];
      key[127 - 8 * (3 * n) -: 8]     = v[23:16];
    end
    it.key_high = key[127:64];
    it.key_low  = key[63:0];
    return it;
  endfunction

  // probes crowded into the lowest 64 bits: many same-byte hits and false positives
  function automatic key_item_t narrow_item(logic func);
    logic [PROBE_COUNT*INDEX_BITS-1:0] p;
    for (int n = 0; n < PROBE_COUNT; n++) begin
      p[n * INDEX_BITS +: INDEX_BITS] = INDEX_BITS'($urandom_range(0, 63));
    end
    return from_probes(func, p);
  endfunction

  function automatic key_item_t random_item(logic func);
    key_item_t it;
    it.func     = func;
    it.key_high = {$urandom, $urandom};
    it.key_low  = {$urandom, $urandom};
    it.key_crc  = 16'($urandom);
    return it;
  endfunction

  // one start transfer after a random gap; start stays high when no gap follows
  task automatic send_item(key_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    func_i     <= it.func;
    key_high_i <= it.key_high;
    key_low_i  <= it.key_low;
    key_crc_i  <= it.key_crc;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_transfer(it);
    if (it.func == FUNC_INSERT) begin
      pool = {pool, it};
    end
  endtask

  initial begin
    key_item_t it;
    int        pick;
    int        flip;
    sb          = new();
    cycle_count = 0;
    no_idle     = 1'b0;
    rst_ni      = 1'b0;
    start      <= 1'b0;
    func_i     <= FUNC_INSERT;
    key_high_i <= '0;
    key_low_i  <= '0;
    key_crc_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty filter answers no at both ends of the index range
    send_item(from_probes(FUNC_QUERY, '0));
    send_item(from_probes(FUNC_QUERY, '1));
    // all six probes on one bit
    send_item(from_probes(FUNC_INSERT, '0));
    send_item(from_probes(FUNC_QUERY, '0));
    send_item(from_probes(FUNC_QUERY, {24'h000001, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0}));
    send_item(from_probes(FUNC_INSERT, '1));
    send_item(from_probes(FUNC_QUERY, '1));
    // answer built from bits of two different inserts
    send_item(from_probes(FUNC_QUERY, {24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'h0, 24'h0,
                                       24'hFFFFFF}));
    // six distinct bits of one byte within one key
    send_item(from_probes(FUNC_INSERT, {24'd6, 24'd4, 24'd3, 24'd2, 24'd1, 24'd5}));
    send_item(from_probes(FUNC_QUERY, {24'd6, 24'd4, 24'd3, 24'd2, 24'd1, 24'd5}));
    send_item(from_probes(FUNC_QUERY, {24'd6, 24'd4, 24'd3, 24'd2, 24'd1, 24'd7}));
    // neighboring bits of one byte set by successive inserts
    send_item(from_probes(FUNC_INSERT, {24'd10, 24'd10, 24'd10, 24'd10, 24'd10, 24'd9}));
    send_item(from_probes(FUNC_INSERT, {24'd11, 24'd11, 24'd11, 24'd11, 24'd11, 24'd8}));
    send_item(from_probes(FUNC_QUERY, {24'd9, 24'd8, 24'd11, 24'd10, 24'd9, 24'd11}));
    // raw field extremes and alternating patterns
    send_item('{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 16'h0000});
    send_item('{FUNC_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 16'h0000});
    send_item('{FUNC_QUERY, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF});
    send_item('{FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 16'hA5A5});
    send_item('{FUNC_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 16'hA5A5});
    send_item('{FUNC_QUERY, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5A5A});

    // random traffic: queries mostly aimed at keys already inserted
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        it = random_item(FUNC_INSERT);
      end else if (pick < 35) begin
        it = narrow_item(FUNC_INSERT);
      end else if (pick < 65) begin
        it      = pool[$urandom_range(0, pool.size() - 1)];
        it.func = FUNC_QUERY;
      end else if (pick < 78) begin
        // one flipped bit of a stored key
        it      = pool[$urandom_range(0, pool.size() - 1)];
        it.func = FUNC_QUERY;
        flip    = $urandom_range(0, 143);
        if (flip < 16) begin
          it.key_crc[flip] = ~it.key_crc[flip];
        end else if (flip < 80) begin
          it.key_low[flip - 16] = ~it.key_low[flip - 16];
        end else begin
          it.key_high[flip - 80] = ~it.key_high[flip - 80];
        end
      end else if (pick < 88) begin
        it = narrow_item(FUNC_QUERY);
      end else begin
        it = random_item(FUNC_QUERY);
      end
      send_item(it);
    end
    start <= 1'b0;

    // drain outstanding answers, then watch for stray strobes
    while (sb.answer_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.answer_q.size() == 0) begin
      $display("bloom_filter_six_probe_unit_tb OK");
    end else begin
      $display("bloom_filter_six_probe_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
